// File: rtl/core/uvtr_pkg.sv
// ---------------------------------------------------------------------------
// uvtr_pkg
// Shared types and constants of the UV triangle overlap rasterizer.
// ---------------------------------------------------------------------------
package uvtr_pkg;

	localparam int FIELD_W   = 18;
	localparam int FRAC_BITS = 16;
	localparam int GRID_BITS = 8;
	localparam int GRID_SIZE = 1 << GRID_BITS;
	localparam int SHIFT     = FRAC_BITS - GRID_BITS;
	localparam int FACE_W    = 12;
	localparam int MAX_FACES = 1 << FACE_W;
	localparam int CNT_W     = FACE_W + 1;
	localparam int OWN_AW    = 2 * GRID_BITS;
	localparam int OWN_DW    = FACE_W + 1;
	localparam int BOX_W     = FIELD_W - SHIFT + 1;
	localparam int CW        = FIELD_W + GRID_BITS + 1;
	localparam int PW        = 2 * CW;
	localparam int EW        = PW + 2;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SETUP,
		ST_MUL,
		ST_INIT,
		ST_SCAN,
		ST_DRAIN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic setup;
		logic mul;
		logic init;
		logic step_x;
		logic step_y;
	} edge_ctl_t;

endpackage

// File: rtl/core/uvtr_ram.sv
// ---------------------------------------------------------------------------
// uvtr_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module uvtr_ram #(
	parameter int AW = 8,
	parameter int DW = 8
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [1 << AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/core/uvtr_edge.sv
// ---------------------------------------------------------------------------
// uvtr_edge
// Edge-function setup and incremental stepping over the bounding box.
// ---------------------------------------------------------------------------
module uvtr_edge (
	input  logic                            clk,
	input  uvtr_pkg::edge_ctl_t             ctl,
	input  logic signed [uvtr_pkg::CW-1:0]  vu [3],
	input  logic signed [uvtr_pkg::CW-1:0]  vv [3],
	input  logic [uvtr_pkg::GRID_BITS-1:0]  x0,
	input  logic [uvtr_pkg::GRID_BITS-1:0]  y0,
	output logic                            covered
);

	localparam int PADW = uvtr_pkg::CW - uvtr_pkg::GRID_BITS - uvtr_pkg::FRAC_BITS;

	logic signed [uvtr_pkg::CW-1:0] px0, py0;
	logic [2:0] neg, pos;

	assign px0 = $signed({{PADW{1'b0}}, x0, {uvtr_pkg::FRAC_BITS{1'b0}}});
	assign py0 = $signed({{PADW{1'b0}}, y0, {uvtr_pkg::FRAC_BITS{1'b0}}});

	for (genvar k = 0; k < 3; k++) begin : g_edge
		localparam int C = (k + 1) % 3;

		logic signed [uvtr_pkg::CW-1:0] dx_q, dy_q, a_q, b_q;
		logic signed [uvtr_pkg::PW-1:0] pl_q, pr_q;
		logic signed [uvtr_pkg::EW-1:0] e_q, erow_q, ash, bsh;

		assign ash = uvtr_pkg::EW'(a_q) <<< uvtr_pkg::FRAC_BITS;
		assign bsh = uvtr_pkg::EW'(b_q) <<< uvtr_pkg::FRAC_BITS;

		always_ff @(posedge clk) begin
			if (ctl.setup) begin
				dx_q <= px0 - vu[C];
				dy_q <= py0 - vv[C];
				a_q  <= vv[k] - vv[C];
				b_q  <= vu[k] - vu[C];
			end
			if (ctl.mul) begin
				pl_q <= dx_q * a_q;
				pr_q <= b_q * dy_q;
			end
			if (ctl.init) begin
				e_q    <= uvtr_pkg::EW'(pl_q) - uvtr_pkg::EW'(pr_q);
				erow_q <= uvtr_pkg::EW'(pl_q) - uvtr_pkg::EW'(pr_q);
			end else if (ctl.step_y) begin
				erow_q <= erow_q - bsh;
				e_q    <= erow_q - bsh;
			end else if (ctl.step_x) begin
				e_q <= e_q + ash;
			end
		end

		assign neg[k] = e_q[uvtr_pkg::EW-1];
		assign pos[k] = !e_q[uvtr_pkg::EW-1] && (e_q != '0);
	end

	assign covered = !((|neg) && (|pos));

endmodule

// File: rtl/core/uv_triangle_overlap_raster_top.sv
// ---------------------------------------------------------------------------
// uv_triangle_overlap_raster_top
// Rasterizes UV triangles on a grid and tracks overlapping faces.
// ---------------------------------------------------------------------------
// After reset the block sweeps the owner grid with busy high.
// Each accepted triangle then passes the setup, multiply and init states,
// one grid point per cycle through the owner grid RAM read-modify-write
// loop, a drain state that waits until the pipeline is empty and the done
// state; an empty box goes through drain and done only, and an ignored
// face (capacity full) goes straight to done. done is high for one cycle
// with the result word; the receiver cannot stall it.
module uv_triangle_overlap_raster_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic signed [uvtr_pkg::FIELD_W-1:0] first_u,
	input  logic signed [uvtr_pkg::FIELD_W-1:0] first_v,
	input  logic signed [uvtr_pkg::FIELD_W-1:0] second_u,
	input  logic signed [uvtr_pkg::FIELD_W-1:0] second_v,
	input  logic signed [uvtr_pkg::FIELD_W-1:0] third_u,
	input  logic signed [uvtr_pkg::FIELD_W-1:0] third_v,
	output logic                                done,
	output logic [uvtr_pkg::FACE_W-1:0]         face_number,
	output logic                                overlap_hit,
	output logic [uvtr_pkg::CNT_W-1:0]          culprit_total,
	output logic                                face_overflow
);

	localparam int GB = uvtr_pkg::GRID_BITS;
	localparam int BW = uvtr_pkg::BOX_W;
	localparam int SH = uvtr_pkg::SHIFT;
	localparam int XP = uvtr_pkg::CW - uvtr_pkg::FIELD_W - SH;

	uvtr_pkg::state_t state_q, state_d;
	uvtr_pkg::edge_ctl_t ectl;

	logic [uvtr_pkg::OWN_AW-1:0] clr_q;
	logic [uvtr_pkg::CNT_W-1:0]  face_cnt_q, cnt_q;
	logic hit_q, ovf_q, pt_v_s1, mk_v_s2, lw_v_q;
	logic [GB-1:0] x0_q, x1_q, y0_q, y1_q, x_q, y_q;
	logic [uvtr_pkg::OWN_AW-1:0] idx_s1;
	logic [uvtr_pkg::FACE_W-1:0] mk_face_s2, lw_face_q;
	logic signed [uvtr_pkg::CW-1:0] vu_q [3], vv_q [3];

	logic accept, is_full, box_empty, covered, scan, row_end, last;
	logic signed [uvtr_pkg::FIELD_W-1:0] in_u [3], in_v [3];
	logic signed [uvtr_pkg::FIELD_W-1:0] lo_u, hi_u, lo_v, hi_v;
	logic signed [BW-1:0] x0s, x1s, y0s, y1s, x0c, x1c, y0c, y1c;
	logic signed [uvtr_pkg::FIELD_W:0] hu_r, hv_r;

	logic own_we, cul_we, own_hit, mark_now, mark_wr, inc_a;
	logic [uvtr_pkg::OWN_AW-1:0] own_waddr;
	logic [uvtr_pkg::OWN_DW-1:0] own_wdata, own_rdata;
	logic [uvtr_pkg::FACE_W-1:0] cul_waddr;
	logic cul_wdata, cul_rdata;

	assign in_u[0] = first_u;
	assign in_u[1] = second_u;
	assign in_u[2] = third_u;
	assign in_v[0] = first_v;
	assign in_v[1] = second_v;
	assign in_v[2] = third_v;

	always_comb begin
		lo_u = in_u[0];
		hi_u = in_u[0];
		lo_v = in_v[0];
		hi_v = in_v[0];
		for (int k = 1; k < 3; k++) begin
			if (in_u[k] < lo_u) lo_u = in_u[k];
			if (in_u[k] > hi_u) hi_u = in_u[k];
			if (in_v[k] < lo_v) lo_v = in_v[k];
			if (in_v[k] > hi_v) hi_v = in_v[k];
		end
	end

	assign hu_r = (uvtr_pkg::FIELD_W + 1)'(hi_u) + $signed((uvtr_pkg::FIELD_W + 1)'((1 << SH) - 1));
	assign hv_r = (uvtr_pkg::FIELD_W + 1)'(hi_v) + $signed((uvtr_pkg::FIELD_W + 1)'((1 << SH) - 1));
	assign x0s  = BW'(lo_u >>> SH);
	assign y0s  = BW'(lo_v >>> SH);
	assign x1s  = hu_r[uvtr_pkg::FIELD_W:SH];
	assign y1s  = hv_r[uvtr_pkg::FIELD_W:SH];
	assign x0c  = x0s[BW-1] ? '0 : x0s;
	assign y0c  = y0s[BW-1] ? '0 : y0s;
	assign x1c  = (x1s > $signed(BW'(uvtr_pkg::GRID_SIZE - 1))) ?
	              $signed(BW'(uvtr_pkg::GRID_SIZE - 1)) : x1s;
	assign y1c  = (y1s > $signed(BW'(uvtr_pkg::GRID_SIZE - 1))) ?
	              $signed(BW'(uvtr_pkg::GRID_SIZE - 1)) : y1s;
	assign box_empty = (x0c > x1c) || (y0c > y1c);

	assign is_full = face_cnt_q >= uvtr_pkg::CNT_W'(uvtr_pkg::MAX_FACES);
	assign accept  = start && !busy;
	assign row_end = x_q == x1_q;
	assign last    = row_end && (y_q == y1_q);

	always_comb begin
		state_d = state_q;
		case (state_q)
			uvtr_pkg::ST_CLEAR: if (&clr_q) state_d = uvtr_pkg::ST_IDLE;
			uvtr_pkg::ST_IDLE: begin
				if (start) begin
					if (is_full) state_d = uvtr_pkg::ST_DONE;
					else if (box_empty) state_d = uvtr_pkg::ST_DRAIN;
					else state_d = uvtr_pkg::ST_SETUP;
				end
			end
			uvtr_pkg::ST_SETUP: state_d = uvtr_pkg::ST_MUL;
			uvtr_pkg::ST_MUL:   state_d = uvtr_pkg::ST_INIT;
			uvtr_pkg::ST_INIT:  state_d = uvtr_pkg::ST_SCAN;
			uvtr_pkg::ST_SCAN:  if (last) state_d = uvtr_pkg::ST_DRAIN;
			uvtr_pkg::ST_DRAIN: if (!pt_v_s1 && !mk_v_s2) state_d = uvtr_pkg::ST_DONE;
			uvtr_pkg::ST_DONE:  state_d = uvtr_pkg::ST_IDLE;
			default:            state_d = uvtr_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		busy        = state_q != uvtr_pkg::ST_IDLE;
		done        = state_q == uvtr_pkg::ST_DONE;
		scan        = state_q == uvtr_pkg::ST_SCAN;
		ectl.setup  = state_q == uvtr_pkg::ST_SETUP;
		ectl.mul    = state_q == uvtr_pkg::ST_MUL;
		ectl.init   = state_q == uvtr_pkg::ST_INIT;
		ectl.step_x = scan && !row_end;
		ectl.step_y = scan && row_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= uvtr_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	uvtr_edge u_edge (
		.clk     (clk),
		.ctl     (ectl),
		.vu      (vu_q),
		.vv      (vv_q),
		.x0      (x0_q),
		.y0      (y0_q),
		.covered (covered)
	);

	// owner grid pipeline: read at scan, compare and write back in the next cycle
	assign own_hit   = pt_v_s1 && own_rdata[uvtr_pkg::FACE_W] &&
	                   (own_rdata[uvtr_pkg::FACE_W-1:0] != face_cnt_q[uvtr_pkg::FACE_W-1:0]);
	assign own_we    = busy && ((state_q == uvtr_pkg::ST_CLEAR) || pt_v_s1);
	assign own_waddr = (state_q == uvtr_pkg::ST_CLEAR) ? clr_q : idx_s1;
	assign own_wdata = (state_q == uvtr_pkg::ST_CLEAR) ? '0 :
	                   {1'b1, face_cnt_q[uvtr_pkg::FACE_W-1:0]};

	uvtr_ram #(.AW(uvtr_pkg::OWN_AW), .DW(uvtr_pkg::OWN_DW)) u_owner (
		.clk   (clk),
		.we    (own_we),
		.waddr (own_waddr),
		.wdata (own_wdata),
		.raddr ({y_q, x_q}),
		.rdata (own_rdata)
	);

	// culprit marks: forward the write of the previous cycle; the face's own
	// mark goes in at done, when the port is idle
	assign mark_now  = cul_rdata || (lw_v_q && (lw_face_q == mk_face_s2));
	assign mark_wr   = mk_v_s2 && !mark_now;
	assign inc_a     = own_hit && !hit_q;
	assign cul_we    = (state_q == uvtr_pkg::ST_CLEAR) || mark_wr || (done && hit_q);
	assign cul_waddr = (state_q == uvtr_pkg::ST_CLEAR) ? clr_q[uvtr_pkg::FACE_W-1:0] :
	                   mark_wr ? mk_face_s2 : face_cnt_q[uvtr_pkg::FACE_W-1:0];
	assign cul_wdata = state_q != uvtr_pkg::ST_CLEAR;

	uvtr_ram #(.AW(uvtr_pkg::FACE_W), .DW(1)) u_culprit (
		.clk   (clk),
		.we    (cul_we),
		.waddr (cul_waddr),
		.wdata (cul_wdata),
		.raddr (own_rdata[uvtr_pkg::FACE_W-1:0]),
		.rdata (cul_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= '0;
			face_cnt_q <= '0;
			cnt_q      <= '0;
			hit_q      <= 1'b0;
			ovf_q      <= 1'b0;
			pt_v_s1    <= 1'b0;
			mk_v_s2    <= 1'b0;
			lw_v_q     <= 1'b0;
		end else begin
			if (state_q == uvtr_pkg::ST_CLEAR) clr_q <= clr_q + 1'b1;
			if (accept) begin
				hit_q <= 1'b0;
				ovf_q <= is_full;
			end else if (inc_a) begin
				hit_q <= 1'b1;
			end
			if (done && !ovf_q) face_cnt_q <= face_cnt_q + 1'b1;
			cnt_q   <= cnt_q + uvtr_pkg::CNT_W'(inc_a) + uvtr_pkg::CNT_W'(mark_wr);
			pt_v_s1 <= scan && covered;
			mk_v_s2 <= own_hit;
			lw_v_q  <= mark_wr;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			for (int k = 0; k < 3; k++) begin
				vu_q[k] <= $signed({{XP{in_u[k][uvtr_pkg::FIELD_W-1]}}, in_u[k], {SH{1'b0}}});
				vv_q[k] <= $signed({{XP{in_v[k][uvtr_pkg::FIELD_W-1]}}, in_v[k], {SH{1'b0}}});
			end
			x0_q <= x0c[GB-1:0];
			x1_q <= x1c[GB-1:0];
			y0_q <= y0c[GB-1:0];
			y1_q <= y1c[GB-1:0];
			x_q  <= x0c[GB-1:0];
			y_q  <= y0c[GB-1:0];
		end else if (scan) begin
			if (row_end) begin
				x_q <= x0_q;
				y_q <= y_q + 1'b1;
			end else begin
				x_q <= x_q + 1'b1;
			end
		end
		idx_s1     <= {y_q, x_q};
		mk_face_s2 <= own_rdata[uvtr_pkg::FACE_W-1:0];
		lw_face_q  <= mk_face_s2;
	end

	assign face_number   = ovf_q ? '0 : face_cnt_q[uvtr_pkg::FACE_W-1:0];
	assign overlap_hit   = hit_q;
	assign culprit_total = cnt_q;
	assign face_overflow = ovf_q;

endmodule
